>>> src/pcmv_pkg.sv
// ----------------------------------------------------------------------------
// pcmv_pkg
// Shared constants and state codes for the periodogram column-variance block.
// ----------------------------------------------------------------------------
`default_nettype none

package pcmv_pkg;

   localparam int CFG_W   = 12;
   localparam int SAMP_W  = 16;
   localparam int MEAN_W  = 33;
   localparam int ACC_W   = 64;
   localparam int VAR_W   = 51;
   localparam int IDX_W   = 2;
   localparam int STATE_W = 4;

   localparam logic [IDX_W-1:0] CFG_FIRST_PERIOD = 2'd0;
   localparam logic [IDX_W-1:0] CFG_LAST_PERIOD  = 2'd1;

   localparam logic [STATE_W-1:0] S_IDLE   = 4'd0;
   localparam logic [STATE_W-1:0] S_PINIT  = 4'd1;
   localparam logic [STATE_W-1:0] S_F_RD   = 4'd2;
   localparam logic [STATE_W-1:0] S_F_WR   = 4'd3;
   localparam logic [STATE_W-1:0] S_M_RD   = 4'd4;
   localparam logic [STATE_W-1:0] S_M_DIV  = 4'd5;
   localparam logic [STATE_W-1:0] S_M_WAIT = 4'd6;
   localparam logic [STATE_W-1:0] S_G_DIV  = 4'd7;
   localparam logic [STATE_W-1:0] S_G_WAIT = 4'd8;
   localparam logic [STATE_W-1:0] S_V_RD   = 4'd9;
   localparam logic [STATE_W-1:0] S_V_MUL  = 4'd10;
   localparam logic [STATE_W-1:0] S_V_SQ   = 4'd11;
   localparam logic [STATE_W-1:0] S_V_ADD  = 4'd12;
   localparam logic [STATE_W-1:0] S_V_DIV  = 4'd13;
   localparam logic [STATE_W-1:0] S_V_WAIT = 4'd14;
   localparam logic [STATE_W-1:0] S_NEXT   = 4'd15;

   localparam logic [VAR_W-1:0] VAR_MAX = {VAR_W{1'b1}};

endpackage

`default_nettype wire

>>> src/pcmv_ram.sv
// ----------------------------------------------------------------------------
// pcmv_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module pcmv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> src/pcmv_div.sv
// ----------------------------------------------------------------------------
// pcmv_div
// Unsigned restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pcmv_div
   import pcmv_pkg::*;
#(
   parameter int DVW = 13
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [ACC_W-1:0] num,
   input  wire logic [DVW-1:0]   den,
   output logic                  done,
   output logic      [ACC_W-1:0] quo
);

   localparam int SW = $clog2(ACC_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [SW-1:0]    step_ff, step_in;
   logic [DVW:0]     rem_ff, rem_in;
   logic [ACC_W-1:0] quo_ff, quo_in;
   logic [DVW-1:0]   den_ff, den_in;
   logic [DVW:0]     rem_sh;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      rem_sh  = {rem_ff[DVW-1:0], quo_ff[ACC_W-1]};
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sh - {1'b0, den_ff};
            quo_in = {quo_ff[ACC_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[ACC_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == SW'(ACC_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      den_ff  <= den_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

`default_nettype wire

>>> src/periodogram_column_mean_variance.sv
// ----------------------------------------------------------------------------
// periodogram_column_mean_variance
// Folds a stored series at each trial period and reports the variance of
// the column means in Q.16.
//
//   channel   ports                                      direction
//   request   start, busy, req_sample_*, req_last_sample  in, busy out
//   response  rsp_valid, rsp_period, rsp_variance, ...    out
//   config    csr_write, csr_index, csr_wdata             in
//
// Samples load at one transfer per cycle while busy is low. After the last
// sample, the S_PINIT state clamps the period range, and then each period P
// is processed in turn; its time grows with the N stored samples and with
// the counts U and E of non-empty and empty columns among the first
// min(P, N). The time is set by the memory ports and the serial divider.
// Reset is synchronous; memories are not cleared. Results appear as
// one-cycle strobes and cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module periodogram_column_mean_variance
   import pcmv_pkg::*;
#(
   parameter int MAX_SAMPLES = 4096,
   parameter int MAX_PERIOD  = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic signed [SAMP_W-1:0] req_sample_value,
   input  wire logic                     req_sample_missing,
   input  wire logic                     req_last_sample,
   output logic                          rsp_valid,
   output logic             [CFG_W-1:0]  rsp_period,
   output logic             [VAR_W-1:0]  rsp_variance,
   output logic                          rsp_variance_missing,
   output logic                          rsp_last_result,
   input  wire logic                     csr_write,
   input  wire logic        [IDX_W-1:0]  csr_index,
   input  wire logic        [CFG_W-1:0]  csr_wdata
);

   localparam int SAW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int CNTW = $clog2(MAX_SAMPLES + 1);
   localparam int PW   = $clog2(MAX_PERIOD + 1);
   localparam int CAW  = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;
   localparam int SUMW = SAMP_W + CNTW;
   localparam int VW   = (SUMW > MEAN_W) ? SUMW : MEAN_W;
   localparam int CRW  = VW + CNTW;
   localparam int XW   = (CNTW > PW) ? CNTW : PW;
   localparam int CLW  = ((PW > CFG_W) ? PW : CFG_W) + 1;

   logic [STATE_W-1:0]     state_ff, state_in;
   logic [CNTW-1:0]        count_ff, count_in;
   logic [CFG_W-1:0]       first_ff, first_in, last_ff, last_in;
   logic [PW-1:0]          p_ff, p_in, plast_ff, plast_in;
   logic [CNTW-1:0]        k_ff, k_in;
   logic [CAW-1:0]         c_ff, c_in;
   logic [PW-1:0]          j_ff, j_in, ncol_ff, ncol_in, used_ff, used_in;
   logic signed [ACC_W-1:0] gsum_ff, gsum_in;
   logic signed [MEAN_W-1:0] gmean_ff, gmean_in;
   logic [ACC_W-1:0]       acc_ff, acc_in;
   logic [MEAN_W-2:0]      m_ff, m_in;
   logic [2*MEAN_W-3:0]    prod_ff, prod_in;
   logic [CNTW-1:0]        cnt_ff, cnt_in;
   logic                   neg_ff, neg_in;
   logic                   rv_ff, rv_in, rmiss_ff, rmiss_in, rlast_ff, rlast_in;
   logic [PW-1:0]          rper_ff, rper_in;
   logic [VAR_W-1:0]       rvar_ff, rvar_in;

   logic                   s_we, s_re, c_we, c_re;
   logic [SAW-1:0]         s_wa, s_ra;
   logic [CAW-1:0]         c_wa, c_ra;
   logic [SAMP_W:0]        s_wd, s_rd;
   logic [CRW-1:0]         c_wd, c_rd;

   logic                   div_start, div_done;
   logic [ACC_W-1:0]       div_num, div_quo;
   logic [CNTW-1:0]        div_den;

   logic [CLW-1:0]         fe, le, fc, lc, lim, maxp;
   logic signed [SAMP_W-1:0] sval;
   logic [CNTW-1:0]        col_cnt;
   logic signed [VW-1:0]   col_val;
   logic signed [MEAN_W-1:0] qmean, cmean;
   logic signed [MEAN_W:0] dval;
   logic [VW-1:0]          mag_sum;
   logic                   accept;

   pcmv_ram #(.WIDTH(SAMP_W + 1), .DEPTH(MAX_SAMPLES)) u_samples (
      .clock(clock), .wr_en(s_we), .wr_addr(s_wa), .wr_data(s_wd),
      .rd_en(s_re), .rd_addr(s_ra), .rd_data(s_rd)
   );

   pcmv_ram #(.WIDTH(CRW), .DEPTH(MAX_PERIOD)) u_columns (
      .clock(clock), .wr_en(c_we), .wr_addr(c_wa), .wr_data(c_wd),
      .rd_en(c_re), .rd_addr(c_ra), .rd_data(c_rd)
   );

   pcmv_div #(.DVW(CNTW)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num),
      .den(div_den), .done(div_done), .quo(div_quo)
   );

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   always_comb begin
      maxp = CLW'(MAX_PERIOD);
      fe   = CLW'(first_ff);
      le   = CLW'(last_ff);
      if (fe == '0) begin
         fc = CLW'(1);
      end else if (fe > maxp) begin
         fc = maxp;
      end else begin
         fc = fe;
      end
      lim = fc + CLW'(63);
      lc  = (le > maxp) ? maxp : le;
      if (lc > lim) begin
         lc = lim;
      end
   end

   always_comb begin
      sval    = s_rd[SAMP_W-1:0];
      col_cnt = c_rd[CRW-1:VW];
      col_val = c_rd[VW-1:0];
      cmean   = c_rd[MEAN_W-1:0];
      qmean   = neg_ff ? -MEAN_W'(div_quo) : MEAN_W'(div_quo);
      mag_sum = col_val[VW-1] ? VW'(-col_val) : VW'(col_val);
      dval    = (MEAN_W + 1)'(cmean) - (MEAN_W + 1)'(gmean_ff);
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      first_in = first_ff;
      last_in  = last_ff;
      p_in     = p_ff;
      plast_in = plast_ff;
      k_in     = k_ff;
      c_in     = c_ff;
      j_in     = j_ff;
      ncol_in  = ncol_ff;
      used_in  = used_ff;
      gsum_in  = gsum_ff;
      gmean_in = gmean_ff;
      acc_in   = acc_ff;
      m_in     = m_ff;
      prod_in  = prod_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      rv_in    = 1'b0;
      rmiss_in = rmiss_ff;
      rlast_in = rlast_ff;
      rper_in  = rper_ff;
      rvar_in  = rvar_ff;
      s_we     = 1'b0;
      s_wa     = count_ff[SAW-1:0];
      s_wd     = {req_sample_missing, req_sample_value};
      s_re     = 1'b0;
      s_ra     = k_ff[SAW-1:0];
      c_we     = 1'b0;
      c_wa     = c_ff;
      c_wd     = c_rd;
      c_re     = 1'b0;
      c_ra     = c_ff;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = cnt_ff;

      if (csr_write) begin
         case (csr_index)
            CFG_FIRST_PERIOD: first_in = csr_wdata;
            CFG_LAST_PERIOD:  last_in  = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (count_ff < CNTW'(MAX_SAMPLES)) begin
                  s_we     = 1'b1;
                  count_in = count_ff + 1'b1;
               end
               if (req_last_sample) begin
                  state_in = S_PINIT;
               end
            end
         end
         S_PINIT: begin
            if (lc < fc) begin
               count_in = '0;
               state_in = S_IDLE;
            end else begin
               p_in     = PW'(fc);
               plast_in = PW'(lc);
               k_in     = '0;
               c_in     = '0;
               state_in = S_F_RD;
            end
         end
         S_F_RD: begin
            if (k_ff == count_ff) begin
               ncol_in  = (XW'(p_ff) < XW'(count_ff)) ? p_ff : PW'(count_ff);
               j_in     = '0;
               used_in  = '0;
               gsum_in  = '0;
               state_in = S_M_RD;
            end else begin
               s_re     = 1'b1;
               c_re     = 1'b1;
               state_in = S_F_WR;
            end
         end
         S_F_WR: begin
            c_we = 1'b1;
            if (XW'(k_ff) < XW'(p_ff)) begin
               c_wd = s_rd[SAMP_W] ? '0 : {CNTW'(1), VW'(sval)};
            end else if (!s_rd[SAMP_W]) begin
               c_wd = {col_cnt + 1'b1, VW'(col_val + VW'(sval))};
            end
            k_in = k_ff + 1'b1;
            c_in = (PW'(c_ff) + 1'b1 == p_ff) ? '0 : c_ff + 1'b1;
            state_in = S_F_RD;
         end
         S_M_RD: begin
            if (j_ff == ncol_ff) begin
               state_in = S_G_DIV;
            end else begin
               c_re     = 1'b1;
               c_ra     = j_ff[CAW-1:0];
               state_in = S_M_DIV;
            end
         end
         S_M_DIV: begin
            if (col_cnt == '0) begin
               j_in     = j_ff + 1'b1;
               state_in = S_M_RD;
            end else begin
               cnt_in    = col_cnt;
               neg_in    = col_val[VW-1];
               div_start = 1'b1;
               div_num   = ACC_W'(mag_sum) << 16;
               div_den   = col_cnt;
               state_in  = S_M_WAIT;
            end
         end
         S_M_WAIT: begin
            if (div_done) begin
               c_we     = 1'b1;
               c_wa     = j_ff[CAW-1:0];
               c_wd     = {cnt_ff, VW'(qmean)};
               gsum_in  = gsum_ff + ACC_W'(qmean);
               used_in  = used_ff + 1'b1;
               j_in     = j_ff + 1'b1;
               state_in = S_M_RD;
            end
         end
         S_G_DIV: begin
            if (used_ff == '0) begin
               rv_in    = 1'b1;
               rmiss_in = 1'b1;
               rvar_in  = '0;
               rper_in  = p_ff;
               rlast_in = (p_ff == plast_ff);
               state_in = S_NEXT;
            end else begin
               neg_in    = gsum_ff[ACC_W-1];
               div_start = 1'b1;
               div_num   = gsum_ff[ACC_W-1] ? ACC_W'(-gsum_ff) : ACC_W'(gsum_ff);
               div_den   = CNTW'(used_ff);
               state_in  = S_G_WAIT;
            end
         end
         S_G_WAIT: begin
            if (div_done) begin
               gmean_in = qmean;
               j_in     = '0;
               acc_in   = '0;
               state_in = S_V_RD;
            end
         end
         S_V_RD: begin
            if (j_ff == ncol_ff) begin
               state_in = S_V_DIV;
            end else begin
               c_re     = 1'b1;
               c_ra     = j_ff[CAW-1:0];
               state_in = S_V_MUL;
            end
         end
         S_V_MUL: begin
            if (col_cnt == '0) begin
               j_in     = j_ff + 1'b1;
               state_in = S_V_RD;
            end else begin
               m_in     = dval[MEAN_W] ? (MEAN_W - 1)'(-dval) : (MEAN_W - 1)'(dval);
               state_in = S_V_SQ;
            end
         end
         S_V_SQ: begin
            prod_in  = (2 * MEAN_W - 2)'(m_ff) * (2 * MEAN_W - 2)'(m_ff);
            state_in = S_V_ADD;
         end
         S_V_ADD: begin
            acc_in   = acc_ff + ACC_W'(prod_ff >> 16);
            j_in     = j_ff + 1'b1;
            state_in = S_V_RD;
         end
         S_V_DIV: begin
            div_start = 1'b1;
            div_num   = acc_ff;
            div_den   = CNTW'(used_ff);
            state_in  = S_V_WAIT;
         end
         S_V_WAIT: begin
            if (div_done) begin
               rv_in    = 1'b1;
               rmiss_in = 1'b0;
               rvar_in  = (div_quo > ACC_W'(VAR_MAX)) ? VAR_MAX : div_quo[VAR_W-1:0];
               rper_in  = p_ff;
               rlast_in = (p_ff == plast_ff);
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            if (p_ff == plast_ff) begin
               count_in = '0;
               state_in = S_IDLE;
            end else begin
               p_in     = p_ff + 1'b1;
               k_in     = '0;
               c_in     = '0;
               state_in = S_F_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         first_ff <= CFG_W'(2);
         last_ff  <= CFG_W'(16);
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         first_ff <= first_in;
         last_ff  <= last_in;
         rv_ff    <= rv_in;
      end
      p_ff     <= p_in;
      plast_ff <= plast_in;
      k_ff     <= k_in;
      c_ff     <= c_in;
      j_ff     <= j_in;
      ncol_ff  <= ncol_in;
      used_ff  <= used_in;
      gsum_ff  <= gsum_in;
      gmean_ff <= gmean_in;
      acc_ff   <= acc_in;
      m_ff     <= m_in;
      prod_ff  <= prod_in;
      cnt_ff   <= cnt_in;
      neg_ff   <= neg_in;
      rmiss_ff <= rmiss_in;
      rlast_ff <= rlast_in;
      rper_ff  <= rper_in;
      rvar_ff  <= rvar_in;
   end

   assign rsp_valid            = rv_ff;
   assign rsp_period           = CFG_W'(rper_ff);
   assign rsp_variance         = rvar_ff;
   assign rsp_variance_missing = rmiss_ff;
   assign rsp_last_result      = rlast_ff;

   // A result transfer is only ever issued in S_NEXT, where the period advances or the block returns to idle.
   a_rsp_in_next: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> (state_ff == S_NEXT))
      else $error("result strobe outside the period advance");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && rlast_ff) |=> (!rv_ff && state_ff == S_IDLE && count_ff == '0))
      else $error("block did not return to idle after the last result");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(MAX_SAMPLES))
      else $error("sample count beyond store depth");

   a_fold_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_F_WR) |-> (PW'(c_ff) < p_ff))
      else $error("column index beyond fold period");

endmodule

`default_nettype wire
